### hdl/fcc_pkg.sv
package fcc_pkg;

    // Largest graph the matrix holds
    localparam int DEF_MAX_NODES = 64;

    // Field widths
    localparam int END_W   = 6;
    localparam int NODE_W  = 7;
    localparam int TOT_W   = 25;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Node count after reset
    localparam logic [NODE_W-1:0] NODE_RST = 7'd64;

    // Count is reduced modulo this value
    localparam logic [TOT_W-1:0] CYCLE_MOD = 25'd20130728;

    // Register index, taken from paddr[2]
    localparam logic REG_NODE_COUNT = 1'b0;

endpackage

### hdl/fcc_ram.sv
module fcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

### hdl/four_cycle_counter.sv
// Edge beat: read rows, write row a, write row b, then ready for the next beat;
// a beat without a stored edge writes nothing. n is node_count capped at MAX_NODES.
// Last beat: one vertex pair per cycle is counted, then the pipeline drains; n < 2 skips the
// pairs. The result sits in an output register so the next graph loads meanwhile;
// a finished total waits in S_OUT while that register is full.
// Synchronous active-low reset clears control, row valid bits, total, output valid; node_count = 64.
module four_cycle_counter
    import fcc_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // edge channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_has_edge,
    input  logic [END_W-1:0]   i_end_a,
    input  logic [END_W-1:0]   i_end_b,
    input  logic               i_last_edge,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TOT_W-1:0]   o_cycle_count,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int W      = MAX_NODES;
    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam int KW     = $clog2(MAX_NODES + 1);
    localparam int GRP    = (MAX_NODES + 7) / 8;
    localparam int PADW   = GRP * 8;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ERD   = 7'b0000010,
        S_EWA   = 7'b0000100,
        S_EWB   = 7'b0001000,
        S_CNT   = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 4'(v[i]);
        end
        return s;
    endfunction

    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_node_count;
    logic [W-1:0]        r_row_vld;
    logic [ADDR_W-1:0]   r_ea, r_eb;
    logic                r_last;
    logic [ADDR_W-1:0]   r_a, r_c, r_nlast;
    logic [W-1:0]        r_below;
    logic [TOT_W-1:0]    r_total;
    logic                r_out_valid;
    logic [TOT_W-1:0]    r_out_count;

    // count pipeline
    logic                r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [ADDR_W-1:0]   r_a1;
    logic                r_va1, r_vc1;
    logic [PADW-1:0]     r_and;
    logic [3:0]          r_part [GRP];
    logic [KW-1:0]       r_k;
    logic [2*KW-1:0]     r_pairs;

    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr, w_raddr0, w_raddr1;
    logic [W-1:0]        w_wdata, w_rdata0, w_rdata1;
    logic                w_in_acc, w_edge_ok, w_start_cnt, w_issue, w_issue_end, w_pipe_busy;
    logic                w_hand;
    logic [NODE_W-1:0]   w_n;
    logic [KW-1:0]       w_ksum;
    logic [2*KW-1:0]     w_prod;
    logic [TOT_W:0]      w_sum;

    fcc_ram #(
        .WIDTH (W),
        .DEPTH (MAX_NODES)
    ) u_rows (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rdata0),
        .o_rdata1 (w_rdata1)
    );

    // Handshakes and register port
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_cycle_count = r_out_count;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_NODE_COUNT) ? PDATA_W'(r_node_count) : '0;
    assign w_in_acc      = i_valid && o_ready;
    // finished total moves to the output register once it is free
    assign w_hand        = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // Edge is stored only when it is a real edge inside the matrix
    assign w_edge_ok = i_has_edge && (i_end_a != i_end_b)
                       && ({1'b0, i_end_a} < (END_W+1)'(MAX_NODES))
                       && ({1'b0, i_end_b} < (END_W+1)'(MAX_NODES));

    // Effective vertex count, saturated to the matrix size
    assign w_n = (r_node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : r_node_count;

    assign w_start_cnt = (w_in_acc && !w_edge_ok && i_last_edge)
                         || (r_state == S_EWB && r_last);
    assign w_issue     = (r_state == S_CNT);
    assign w_issue_end = (r_c == r_nlast) && (r_a == r_nlast - ADDR_W'(1));
    assign w_pipe_busy = r_v1 || r_v2 || r_v3 || r_v4 || r_v5;

    // Memory ports: edge read-modify-write or pair stream
    always_comb begin
        w_raddr0 = w_issue ? r_a : r_ea;
        w_raddr1 = w_issue ? r_c : r_eb;
        w_we     = (r_state == S_EWA) || (r_state == S_EWB);
        if (r_state == S_EWA) begin
            w_waddr = r_ea;
            w_wdata = (w_rdata0 & {W{r_row_vld[r_ea]}}) | (W'(1) << r_eb);
        end else begin
            w_waddr = r_eb;
            w_wdata = (w_rdata1 & {W{r_row_vld[r_eb]}}) | (W'(1) << r_ea);
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_edge_ok) begin
                        n_state = S_ERD;
                    end else if (i_last_edge) begin
                        n_state = (w_n < NODE_W'(2)) ? S_DRAIN : S_CNT;
                    end
                end
            end
            S_ERD:   n_state = S_EWA;
            S_EWA:   n_state = S_EWB;
            S_EWB: begin
                if (r_last) begin
                    n_state = (w_n < NODE_W'(2)) ? S_DRAIN : S_CNT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CNT: begin
                if (w_issue_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_pipe_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_hand) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NODE_RST;
            r_row_vld    <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
            r_out_count  <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_v5         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && pready && paddr[2] == REG_NODE_COUNT) begin
                r_node_count <= pwdata[NODE_W-1:0];
            end
            if (r_state == S_EWA) begin
                r_row_vld[r_ea] <= 1'b1;
            end
            if (r_state == S_EWB) begin
                r_row_vld[r_eb] <= 1'b1;
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            // accumulate, one conditional subtract keeps the total reduced
            if (r_v5) begin
                r_total <= (w_sum >= (TOT_W+1)'(CYCLE_MOD))
                           ? TOT_W'(w_sum - (TOT_W+1)'(CYCLE_MOD)) : TOT_W'(w_sum);
            end
            // output register: load on hand-off, free when the beat is taken
            if (w_hand) begin
                r_out_valid <= 1'b1;
                r_out_count <= r_total;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            // total handed off: matrix and total start empty
            if (w_hand) begin
                r_row_vld <= '0;
                r_total   <= '0;
            end
        end
    end

    // Edge beat capture and pair counters
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ea   <= i_end_a[ADDR_W-1:0];
            r_eb   <= i_end_b[ADDR_W-1:0];
            r_last <= i_last_edge;
        end
        if (w_start_cnt) begin
            r_a     <= '0;
            r_c     <= ADDR_W'(1);
            r_nlast <= ADDR_W'(w_n - NODE_W'(1));
            r_below <= (w_n >= NODE_W'(MAX_NODES)) ? {W{1'b1}}
                       : (W'(1) << w_n[ADDR_W-1:0]) - W'(1);
        end else if (w_issue) begin
            if (r_c == r_nlast) begin
                r_a <= r_a + ADDR_W'(1);
                r_c <= r_a + ADDR_W'(2);
            end else begin
                r_c <= r_c + ADDR_W'(1);
            end
        end
    end

    // Shared count pipeline: mask, partial popcount, sum, k*(k-1)/2
    always_comb begin
        w_ksum = '0;
        for (int g = 0; g < GRP; g++) begin
            w_ksum = w_ksum + KW'(r_part[g]);
        end
        w_prod = (2*KW)'(r_k) * (2*KW)'(r_k - KW'(1));
        w_sum  = (TOT_W+1)'(r_total) + (TOT_W+1)'(r_pairs);
    end

    always_ff @(posedge i_clk) begin
        r_a1  <= r_a;
        r_va1 <= r_row_vld[r_a];
        r_vc1 <= r_row_vld[r_c];
        r_and <= PADW'(w_rdata0 & w_rdata1 & {W{r_va1 && r_vc1}} & r_below
                       & (({W{1'b1}} << r_a1) << 1));
        for (int g = 0; g < GRP; g++) begin
            r_part[g] <= pop8(r_and[g*8 +: 8]);
        end
        r_k     <= w_ksum;
        r_pairs <= w_prod >> 1;
    end

    // A total is handed off only after every pair has left the pipeline
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !w_pipe_busy)
        else $error("total handed off while pairs still in flight");

    // Hand-off empties matrix and total
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hand |=> (r_row_vld == '0 && r_total == '0))
        else $error("graph state not cleared after hand-off");

    // Total stays reduced
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total < CYCLE_MOD)
        else $error("total not reduced");

    // No matrix write while pairs are counted
    a_no_write_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || w_issue) |-> !w_we)
        else $error("matrix written during count");

    // A waiting result beat holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_cycle_count)))
        else $error("result beat changed while waiting");

endmodule
